// ===== hdl/cbd_pkg.sv =====
// Shared types, constants and field layout for the circular byte deque.
package cbd_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_PUSH_FRONT = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic exec;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic pop_hit;
  } sts_t;

endpackage

// ===== hdl/circular_byte_deque.sv =====
// Top level of the circular byte deque.
//
// One request enters on the s_axis channel: tdata holds the operation
// (push back, pop front, push front, pop back) and a byte. Exactly one
// result leaves on the m_axis channel: the popped byte (zero on pushes
// and errors), a status (ok, full on push, empty on pop) and an empty
// flag for the deque after the request. The deque holds DEPTH-1 bytes.
//
// Requests are handled one at a time. A push or a failed pop presents
// its result in the cycle after acceptance; a successful pop passes
// through the read state first, as the slot store's read port is
// registered. The next request is taken the cycle after the result is
// taken.
//
// Reset puts both indices at the last slot, so the deque starts empty;
// the slot store itself is not cleared. While m_axis_tready is low the
// result is held and s_axis_tready stays low.
module circular_byte_deque
  import cbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // mode[1:0], data_in[9:2]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // read_data[7:0], status[9:8], is_empty[10]
);

  cmd_t cmd;
  sts_t sts;

  cbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbd_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(m_axis_tdata)
  );

endmodule

// ===== hdl/cbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cbd_ctrl.sv =====
// Request sequencer for the circular byte deque.
module cbd_ctrl
  import cbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.pop_hit ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured read not presented");

  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && sts_i.pop_hit) |=> cmd_o.capture)
    else $error("pop without read capture");

endmodule

// ===== hdl/cbd_dp.sv =====
// Index registers, slot store and result register of the circular byte deque.
module cbd_dp
  import cbd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IN_W-1:0] in_data_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic [OUT_W-1:0] out_data_o
);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  logic [IDX_W-1:0]  front_q, front_d, back_q, back_d;
  logic [BYTE_W-1:0] read_q;
  status_e           status_q, status_d;
  logic              empty_q;

  mode_e             mode;
  logic [BYTE_W-1:0] din;
  logic              is_empty, full, pop_hit;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [BYTE_W-1:0] rdata;

  assign mode     = mode_e'(in_data_i[1:0]);
  assign din      = in_data_i[2 +: BYTE_W];
  assign is_empty = (front_q == back_q);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    status_d = STATUS_OK;
    full     = 1'b0;
    pop_hit  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = back_q;
    raddr    = back_q;
    unique case (mode)
      MODE_PUSH_BACK: begin
        full  = (next_idx(back_q) == front_q);
        waddr = next_idx(back_q);
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          we     = cmd_i.exec;
          back_d = next_idx(back_q);
        end
      end
      MODE_POP_FRONT: begin
        raddr = next_idx(front_q);
        if (is_empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          pop_hit = 1'b1;
          re      = cmd_i.exec;
          front_d = next_idx(front_q);
        end
      end
      MODE_PUSH_FRONT: begin
        full  = (prev_idx(front_q) == back_q);
        waddr = front_q;
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          we      = cmd_i.exec;
          front_d = prev_idx(front_q);
        end
      end
      MODE_POP_BACK: begin
        raddr = back_q;
        if (is_empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          pop_hit = 1'b1;
          re      = cmd_i.exec;
          back_d  = prev_idx(back_q);
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  assign sts_o.pop_hit = pop_hit;

  cbd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(din),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= IDX_LAST;
      back_q  <= IDX_LAST;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      read_q   <= '0;
      status_q <= status_d;
      empty_q  <= (front_d == back_d);
    end else if (cmd_i.capture) begin
      read_q <= rdata;
    end
  end

  assign out_data_o = {5'd0, empty_q, status_q, read_q};

  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (status_d != STATUS_OK)) |=> ($stable(front_q) && $stable(back_q)))
    else $error("failed request moved an index");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (empty_q == (front_q == back_q)))
    else $error("empty flag disagrees with indices");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("store written and read by one request");

endmodule
